// ----- rtl/bat_pkg.sv -----
// Shared types, codes and constants of the bounded array table engine.
`default_nettype none
package bat_pkg;

    // Built depth limits and the width that holds any position or count.
    localparam int DEPTH_DEFAULT = 64;
    localparam int MAX_DEPTH     = 1024;
    localparam int POS_W         = $clog2(MAX_DEPTH + 1);

    // Fixed field widths.
    localparam int OP_W    = 3;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [INDEX_W-1:0]        found_index;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        count_now;
    } out_item_t;

    // Command broadcast to every cell on the edge an item is accepted.
    // Operation flags are already qualified by accept and by the range checks.
    typedef struct packed {
        logic                      do_get;
        logic                      do_set;
        logic                      do_append;
        logic                      do_search;
        logic                      do_remove;
        logic [POS_W-1:0]          idx;
        logic [POS_W-1:0]          cnt;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/bat_cell.sv -----
// One storage cell of the array chain: holds one entry and its per-item flags.
`default_nettype none
module bat_cell #(
    parameter int POS = 0
) (
    input  wire logic                                clk,
    input  wire bat_pkg::cmd_t                       cmd,
    input  wire logic signed [bat_pkg::VALUE_W-1:0]  next_data,
    output logic signed [bat_pkg::VALUE_W-1:0]       data,
    output logic                                     hit,
    output logic signed [bat_pkg::VALUE_W-1:0]       rd_part
);

    localparam int PW = bat_pkg::POS_W;
    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic signed [bat_pkg::VALUE_W-1:0] data_reg;
    logic                               hit_reg;
    logic signed [bat_pkg::VALUE_W-1:0] rd_reg;

    logic sel;
    logic live;
    logic shift_in;

    assign sel      = (MY_POS == cmd.idx);
    assign live     = (MY_POS < cmd.cnt);
    // Take the neighbor's entry when at or past the removed slot and below the last one.
    assign shift_in = cmd.do_remove && (MY_POS >= cmd.idx) && ((MY_POS + 1'b1) < cmd.cnt);

    always_ff @(posedge clk)
    begin
        priority if (cmd.do_set && sel)
        begin
            data_reg <= cmd.value;
        end
        else if (cmd.do_append && (MY_POS == cmd.cnt))
        begin
            data_reg <= cmd.value;
        end
        else if (shift_in)
        begin
            data_reg <= next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_get || cmd.do_search)
        begin
            hit_reg <= cmd.do_search && live && (data_reg == cmd.value);
            rd_reg  <= (cmd.do_get && sel) ? data_reg : '0;
        end
    end

    assign data    = data_reg;
    assign hit     = hit_reg;
    assign rd_part = rd_reg;

endmodule
`default_nettype wire

// ----- rtl/bat_reduce.sv -----
// Collects the cells' flags: lowest matching position and the read word.
`default_nettype none
module bat_reduce #(
    parameter int DEPTH = bat_pkg::DEPTH_DEFAULT
) (
    input  wire logic [DEPTH-1:0]                   hits,
    input  wire logic signed [bat_pkg::VALUE_W-1:0] rd_parts [DEPTH],
    output logic                                    any_hit,
    output logic [bat_pkg::POS_W-1:0]               found,
    output logic signed [bat_pkg::VALUE_W-1:0]      rd_word
);

    localparam int PW = bat_pkg::POS_W;

    logic [DEPTH-1:0] lowest;

    // Isolate the lowest set bit.
    assign lowest  = hits & (~hits + 1'b1);
    assign any_hit = |hits;

    always_comb
    begin
        found   = '0;
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found   = found | (lowest[i] ? PW'(i) : '0);
            rd_word = rd_word | rd_parts[i];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bounded_array_table_engine.sv -----
// Top level of the bounded array table engine: control, count and the cell chain.
`default_nettype none
// A bounded array of signed 32-bit words kept in a row of DEPTH cells, one
// entry per cell, with a fill count. Each input item (get, set, append,
// search, remove, clear) yields exactly one result item carrying read_value,
// found_index, status and count_now. On the accept edge every cell acts at
// once (writes, the one-step shift toward the front for remove, and its
// compare for search); the reduce unit then loads the lowest match and the
// read word into the output register, a step a stalled output holds back.
// The next item is taken while a finished result still waits. The user
// must write capacity_limit through cfg_write/cfg_data only while idle;
// the block does not enforce this. A value above DEPTH acts as DEPTH.
// Lowering it below the count keeps the entries, appends then report full.
// Entries have no reset and need none: reads stay below the fill count.
module bounded_array_table_engine #(
    parameter int DEPTH = bat_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire bat_pkg::in_item_t           in_item,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output bat_pkg::out_item_t               out_item,
    input  wire logic                        cfg_write,
    input  wire logic [bat_pkg::CAP_W-1:0]   cfg_data
);

    localparam int PW    = bat_pkg::POS_W;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Control and count state.
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [bat_pkg::CAP_W-1:0]     cap_reg;
    logic                          busy_reg;
    logic                          out_valid_reg;
    logic                          pend_search_reg;
    logic                          pend_get_reg;
    logic [bat_pkg::STAT_W-1:0]    pend_status_reg, pend_status_next;
    bat_pkg::out_item_t            out_item_reg, out_item_next;

    logic          in_accept;
    logic          finish;
    bat_pkg::cmd_t cmd;

    logic [PW-1:0] idx_w;
    logic [PW-1:0] cnt_w;
    logic [PW-1:0] cap_w;
    logic [PW-1:0] limit_w;
    logic          in_range;
    logic          has_room;

    // Cell chain wiring.
    logic signed [bat_pkg::VALUE_W-1:0] cell_data [DEPTH];
    logic signed [bat_pkg::VALUE_W-1:0] cell_rd   [DEPTH];
    logic [DEPTH-1:0]                   cell_hit;

    logic                               any_hit;
    logic [PW-1:0]                      found;
    logic signed [bat_pkg::VALUE_W-1:0] rd_word;

    // A single item is in flight between its accept edge and its result load.
    assign in_stall  = busy_reg;
    assign in_accept = in_valid && !busy_reg;
    assign finish    = busy_reg && (!out_valid_reg || !out_stall);

    // Range and room checks, all in the common position width.
    assign idx_w    = PW'(in_item.index);
    assign cnt_w    = PW'(fill_reg);
    assign cap_w    = PW'(cap_reg);
    assign limit_w  = (cap_w < PW'(DEPTH)) ? cap_w : PW'(DEPTH);
    assign in_range = (idx_w < cnt_w);
    assign has_room = (cnt_w < limit_w);

    // Decode: flags for the cells, the next count and the status known now.
    always_comb
    begin
        cmd               = '0;
        cmd.idx           = idx_w;
        cmd.cnt           = cnt_w;
        cmd.value         = in_item.value;
        fill_next         = fill_reg;
        pend_status_next  = bat_pkg::ST_OK;
        if (in_accept)
        begin
            unique case (in_item.opcode)
                bat_pkg::OP_GET:
                begin
                    cmd.do_get       = in_range;
                    pend_status_next = in_range ? bat_pkg::ST_OK : bat_pkg::ST_RANGE;
                end
                bat_pkg::OP_SET:
                begin
                    cmd.do_set       = in_range;
                    pend_status_next = in_range ? bat_pkg::ST_OK : bat_pkg::ST_RANGE;
                end
                bat_pkg::OP_APPEND:
                begin
                    cmd.do_append    = has_room;
                    fill_next        = has_room ? fill_reg + 1'b1 : fill_reg;
                    pend_status_next = has_room ? bat_pkg::ST_OK : bat_pkg::ST_FULL;
                end
                bat_pkg::OP_SEARCH:
                begin
                    cmd.do_search    = 1'b1;
                end
                bat_pkg::OP_REMOVE:
                begin
                    cmd.do_remove    = in_range;
                    fill_next        = in_range ? fill_reg - 1'b1 : fill_reg;
                    pend_status_next = in_range ? bat_pkg::ST_OK : bat_pkg::ST_RANGE;
                end
                bat_pkg::OP_CLEAR:
                begin
                    fill_next        = '0;
                end
                default:
                begin
                    // unused opcodes: no effect, ok status
                end
            endcase
        end
    end

    // The row of cells; each one hands its entry to the cell in front of it.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [bat_pkg::VALUE_W-1:0] neighbor;
        if (i == DEPTH - 1)
        begin : g_last
            assign neighbor = cell_data[i];
        end
        else
        begin : g_mid
            assign neighbor = cell_data[i + 1];
        end

        bat_cell #(
            .POS (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .next_data (neighbor),
            .data      (cell_data[i]),
            .hit       (cell_hit[i]),
            .rd_part   (cell_rd[i])
        );
    end

    bat_reduce #(
        .DEPTH (DEPTH)
    ) u_reduce (
        .hits     (cell_hit),
        .rd_parts (cell_rd),
        .any_hit  (any_hit),
        .found    (found),
        .rd_word  (rd_word)
    );

    // Result assembly from the reduced cell flags. The cells keep their read
    // word from the last get or search, so it only counts for an in-range get.
    always_comb
    begin
        out_item_next             = out_item_reg;
        out_item_next.read_value  = pend_get_reg ? rd_word : '0;
        out_item_next.count_now   = bat_pkg::COUNT_W'(fill_reg);
        if (pend_search_reg)
        begin
            out_item_next.found_index = any_hit ? bat_pkg::INDEX_W'(found) : '0;
            out_item_next.status      = any_hit ? bat_pkg::ST_OK : bat_pkg::ST_MISS;
        end
        else
        begin
            out_item_next.found_index = '0;
            out_item_next.status      = pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            cap_reg       <= bat_pkg::CAP_RESET;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_search_reg <= (in_item.opcode == bat_pkg::OP_SEARCH);
            pend_get_reg    <= cmd.do_get;
            pend_status_reg <= pend_status_next;
        end
        if (finish)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

// ----- rtl/bat_checker.sv -----
// Port-level checker for the bounded array table engine and its bind.
`default_nettype none
module bat_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire bat_pkg::out_item_t        out_item
);

    // One item in flight: an accepted item raises the stall in the cycle after its accept.
    a_accept_then_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken back to back");

    // A result waiting at the output stays and holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");

    // Failed operations carry zeros in the data fields.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != bat_pkg::ST_OK) |->
            (out_item.read_value == '0 && out_item.found_index == '0))
        else $error("error result with nonzero data");

    // A nonzero read word only comes with ok status.
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.read_value != '0) |-> (out_item.status == bat_pkg::ST_OK))
        else $error("read word without ok status");

endmodule

bind bounded_array_table_engine bat_checker u_bat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the bounded array table engine: shadow array, stimulus, checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bat_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    // The two opcodes the block leaves unused; they must act as a no-op.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // Random items per capacity setting, and the capacity sequence itself.
    // It starts above DEPTH, drops below the fill count, hits zero and one,
    // and comes back to the built depth.
    localparam int PHASE_ITEMS = 165;
    localparam int PHASE_COUNT = 8;
    localparam logic [CAP_W-1:0] CAP_PLAN [PHASE_COUNT] =
        '{7'd127, 7'd9, 7'd0, 7'd1, 7'd64, 7'd33, 7'd100, 7'd64};

    // Cycles with no accept on either side before the run is declared hung.
    // Worst correct case is a long source gap plus a long sink stall.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let pass once nothing is outstanding.
    localparam int DRAIN_SETTLE = 4;

    // Shadow of the array: holds the words, the fill count and the capacity,
    // and lines up the result each accepted item should produce.
    class array_scoreboard;
        logic signed [VALUE_W-1:0] words [DEPTH];
        int unsigned               fill;
        int unsigned               cap;
        out_item_t                 pending_results [$];
        int unsigned               mismatches;
        int unsigned               checked;

        function new();
            fill       = 0;
            cap        = CAP_RESET;
            mismatches = 0;
            checked    = 0;
            foreach (words[i])
                words[i] = '0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap = value;
        endfunction

        // Entries the array may hold right now: capacity clipped to DEPTH.
        function int unsigned room();
            return (cap < DEPTH) ? cap : DEPTH;
        endfunction

        // Applies one accepted item to the shadow array and queues its result.
        function void note_item(in_item_t it);
            out_item_t   r;
            int unsigned i;
            r        = '0;
            r.status = ST_OK;
            case (it.opcode)
                OP_GET:
                begin
                    if (it.index < fill)
                        r.read_value = words[it.index];
                    else
                        r.status = ST_RANGE;
                end
                OP_SET:
                begin
                    if (it.index < fill)
                        words[it.index] = it.value;
                    else
                        r.status = ST_RANGE;
                end
                OP_APPEND:
                begin
                    if (fill < room())
                    begin
                        words[fill] = it.value;
                        fill++;
                    end
                    else
                        r.status = ST_FULL;
                end
                OP_SEARCH:
                begin
                    r.status = ST_MISS;
                    i = 0;
                    while (i < fill && r.status == ST_MISS)
                    begin
                        if (words[i] == it.value)
                        begin
                            r.found_index = INDEX_W'(i);
                            r.status      = ST_OK;
                        end
                        i++;
                    end
                end
                OP_REMOVE:
                begin
                    if (it.index < fill)
                    begin
                        for (i = it.index; i + 1 < fill; i++)
                            words[i] = words[i + 1];
                        fill--;
                    end
                    else
                        r.status = ST_RANGE;
                end
                OP_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            r.count_now = COUNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compares one delivered result with the oldest outstanding one.
        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0h count_now %0h",
                       got.status, got.count_now);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            match_field("read_value", want.read_value, got.read_value);
            match_field("found_index", want.found_index, got.found_index);
            match_field("status", want.status, got.status);
            match_field("count_now", want.count_now, got.count_now);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_write = 1'b0;
    logic [CAP_W-1:0] cfg_data = '0;

    array_scoreboard sb;

    // Pacing knobs: when set, that side runs flat out for a stretch.
    bit quiet_source = 1'b0;
    bit quiet_sink   = 1'b0;

    int unsigned op_tally [8];
    int unsigned status_tally [4];
    int unsigned caps_written = 0;
    int unsigned idle_cycles  = 0;

    always #5 clk = ~clk;

    bounded_array_table_engine #(
        .DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data)
    );

    // Everything is driven with NBAs at posedge, so sampling at posedge sees
    // the values from before the edge - the same ones the block sees.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(out_item);
            status_tally[out_item.status]++;
        end
    end

    // Hang detector: only cycles where neither side moves an item count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Sink back-pressure: short runs of ready, then mostly short stalls with
    // the odd long one. Each assignment is followed by at least one edge.
    initial
    begin : sink_pacing
        int span;
        wait (rst_n === 1'b1);
        forever
        begin
            span = $urandom_range(1, 12);
            out_stall <= 1'b0;
            repeat (span) @(posedge clk);
            if (!quiet_sink)
            begin
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
            end
        end
    end

    // Source idle length after an item: mostly back to back, some short
    // gaps, a few long ones.
    function automatic int source_gap();
        int roll;
        if (quiet_source)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Presents one item, holds it until taken, records it, then maybe idles.
    // valid stays high across back-to-back items; it is only lowered for a gap.
    task automatic drive_item(in_item_t it);
        int gap;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
        op_tally[it.opcode]++;
        gap = source_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(logic [OP_W-1:0] op, int idx, logic [VALUE_W-1:0] val);
        in_item_t it;
        it.opcode = op;
        it.index  = INDEX_W'(idx);
        it.value  = val;
        drive_item(it);
    endtask

    // Holds the source off until every outstanding result has been delivered.
    // Polled on negedge so the answer does not hinge on the monitor's order.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // One-cycle register write; only called with the block drained.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        cfg_data  <= cap;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_capacity(cap);
        caps_written++;
        @(posedge clk);
    endtask

    // A word already in the array, so searches hit and duplicates appear.
    function automatic logic [VALUE_W-1:0] stored_word();
        return sb.words[$urandom_range(0, sb.fill - 1)];
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3 && sb.fill > 0)
            return stored_word();
        if (roll == 3)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly in-range positions, including the last one; the rest anywhere.
    function automatic int pick_index();
        if (sb.fill > 0 && $urandom_range(0, 4) != 0)
            return $urandom_range(0, sb.fill - 1);
        return $urandom_range(0, 63);
    endfunction

    // Operation mix: a growing stretch fills the array toward its limit,
    // a shrinking one removes entries so the shift path sees every length.
    function automatic in_item_t pick_random_item(bit grow);
        in_item_t it;
        int       roll;
        roll      = $urandom_range(0, 99);
        it.value  = pick_value();
        it.index  = INDEX_W'(pick_index());
        if (roll < (grow ? 1 : 3))
            it.opcode = OP_CLEAR;
        else if (roll < (grow ? 3 : 5))
            it.opcode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        else if (roll < (grow ? 60 : 15))
            it.opcode = OP_APPEND;
        else if (roll < (grow ? 66 : 55))
            it.opcode = OP_REMOVE;
        else if (roll < 75)
            it.opcode = OP_GET;
        else if (roll < 85)
            it.opcode = OP_SET;
        else
        begin
            it.opcode = OP_SEARCH;
            if (sb.fill > 0 && $urandom_range(0, 9) < 7)
                it.value = stored_word();
        end
        return it;
    endfunction

    initial
    begin : stimulus
        in_item_t it;
        sb = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-array errors, field extremes, duplicates, shift on
        // remove, removal of the last entry, unused opcodes, clear.
        send_op(OP_GET, 0, 0);                  // empty: index not below count
        send_op(OP_SET, 63, 32'h0000_1234);
        send_op(OP_REMOVE, 0, 0);
        send_op(OP_SEARCH, 0, 0);               // empty: not found
        send_op(OP_APPEND, 0, 32'h7FFF_FFFF);
        send_op(OP_APPEND, 63, 32'h8000_0000);
        send_op(OP_APPEND, 0, 32'hFFFF_FFFF);
        send_op(OP_APPEND, 0, 32'h0000_0000);
        send_op(OP_APPEND, 0, 32'hFFFF_FFFF);   // duplicate of entry 2
        send_op(OP_GET, 1, 0);
        send_op(OP_GET, 5, 0);                  // index equal to count
        send_op(OP_SET, 3, 32'h5555_5555);
        send_op(OP_SEARCH, 0, 32'hFFFF_FFFF);   // lowest of two matches
        send_op(OP_SEARCH, 0, 32'h5555_5555);
        send_op(OP_SEARCH, 0, 32'h0000_0011);
        send_op(OP_REMOVE, 0, 0);               // everything shifts down
        send_op(OP_GET, 0, 0);
        send_op(OP_REMOVE, 3, 0);               // last entry, nothing shifts
        send_op(OP_SEARCH, 0, 32'hFFFF_FFFF);
        send_op(OP_SPARE_LO, 63, 32'hFFFF_FFFF);
        send_op(OP_SPARE_HI, 0, 32'h0000_0005);
        send_op(OP_CLEAR, 0, 0);
        send_op(OP_GET, 0, 0);                  // old words no longer reachable
        send_op(OP_SEARCH, 0, 32'hFFFF_FFFF);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            write_capacity(CAP_PLAN[p]);
            quiet_source = ($urandom_range(0, 3) == 0);
            quiet_sink   = ($urandom_range(0, 3) == 0);

            // At the built depth, fill to the brim, push past it, read the top.
            if (p == 4)
            begin
                while (sb.fill < sb.room())
                    send_op(OP_APPEND, $urandom_range(0, 63), $urandom);
                repeat (3) send_op(OP_APPEND, $urandom_range(0, 63), $urandom);
                send_op(OP_GET, 63, 0);
                send_op(OP_SEARCH, 0, sb.words[63]);
            end

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                begin
                    quiet_source = ($urandom_range(0, 3) == 0);
                    quiet_sink   = ($urandom_range(0, 3) == 0);
                end
                it = pick_random_item(k < (PHASE_ITEMS * 2) / 3);
                drive_item(it);
                // Occasionally let the pipe run dry mid-phase.
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);

        if (sb.pending_results.size() != 0)
        begin
            $error("%0d results never arrived", sb.pending_results.size());
            sb.mismatches++;
        end

        $display("Ran %0d capacity settings; ops get %0d set %0d append %0d search %0d",
                 caps_written, op_tally[OP_GET], op_tally[OP_SET],
                 op_tally[OP_APPEND], op_tally[OP_SEARCH]);
        $display("  remove %0d clear %0d unused %0d; %0d results: ok %0d full %0d range %0d miss %0d",
                 op_tally[OP_REMOVE], op_tally[OP_CLEAR],
                 op_tally[OP_SPARE_LO] + op_tally[OP_SPARE_HI], sb.checked,
                 status_tally[ST_OK], status_tally[ST_FULL],
                 status_tally[ST_RANGE], status_tally[ST_MISS]);

        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
